// ===== rtl/btpc_pkg.sv =====
// Shared types and constants of the barometric compensation block.
package btpc_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int QBITS  = 37;
	localparam int DEN_W  = 42;
	localparam int NUM_W  = 80;

	typedef enum logic [2:0] {
		REG_T1_T2 = 3'd0,
		REG_T3_P1 = 3'd1,
		REG_P2_P3 = 3'd2,
		REG_P4_P5 = 3'd3,
		REG_P6_P7 = 3'd4,
		REG_P8_P9 = 3'd5
	} reg_idx_t;

	localparam logic signed [24:0] T_FINE_REF = 25'sd128000;
	localparam logic [20:0] P_FULL = 21'd1048576;
	localparam logic signed [59:0] P1_BIAS = 60'sh000_8000_0000_0000;
	localparam logic signed [80:0] Q_SCALE = 81'sd3125;
	localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
	localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

	typedef struct packed {
		logic [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} calib_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic signed [DEN_W-1:0] den;
		logic signed [NUM_W-1:0] num;
	} front_t;

	typedef struct packed {
		logic signed [15:0] temp;
		logic err;
		logic neg;
		logic [QBITS-1:0] qmag;
	} quot_t;

endpackage

// ===== rtl/btpc_cfg.sv =====
// Calibration register file behind the APB-style port.
module btpc_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [btpc_pkg::ADDR_W-1:0] paddr,
	input  logic [btpc_pkg::DATA_W-1:0] pwdata,
	output logic [btpc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output btpc_pkg::calib_t calib
);

	logic [31:0] t1t2_q, t3p1_q, p2p3_q, p4p5_q, p6p7_q, p8p9_q;
	btpc_pkg::reg_idx_t idx;
	logic wr;

	assign idx = btpc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1t2_q <= '0;
			t3p1_q <= '0;
			p2p3_q <= '0;
			p4p5_q <= '0;
			p6p7_q <= '0;
			p8p9_q <= '0;
		end else if (wr) begin
			unique case (idx)
				btpc_pkg::REG_T1_T2: t1t2_q <= pwdata;
				btpc_pkg::REG_T3_P1: t3p1_q <= pwdata;
				btpc_pkg::REG_P2_P3: p2p3_q <= pwdata;
				btpc_pkg::REG_P4_P5: p4p5_q <= pwdata;
				btpc_pkg::REG_P6_P7: p6p7_q <= pwdata;
				btpc_pkg::REG_P8_P9: p8p9_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			btpc_pkg::REG_T1_T2: prdata = t1t2_q;
			btpc_pkg::REG_T3_P1: prdata = t3p1_q;
			btpc_pkg::REG_P2_P3: prdata = p2p3_q;
			btpc_pkg::REG_P4_P5: prdata = p4p5_q;
			btpc_pkg::REG_P6_P7: prdata = p6p7_q;
			btpc_pkg::REG_P8_P9: prdata = p8p9_q;
			default: prdata = '0;
		endcase
	end

	assign calib.t1 = t1t2_q[31:16];
	assign calib.t2 = t1t2_q[15:0];
	assign calib.t3 = t3p1_q[31:16];
	assign calib.p1 = t3p1_q[15:0];
	assign calib.p2 = p2p3_q[31:16];
	assign calib.p3 = p2p3_q[15:0];
	assign calib.p4 = p4p5_q[31:16];
	assign calib.p5 = p4p5_q[15:0];
	assign calib.p6 = p6p7_q[31:16];
	assign calib.p7 = p6p7_q[15:0];
	assign calib.p8 = p8p9_q[31:16];
	assign calib.p9 = p8p9_q[15:0];

endmodule

// ===== rtl/btpc_front.sv =====
// Front pipeline: fine temperature, temperature output, pressure numerator and divisor.
module btpc_front (
	input  logic clk,
	input  logic arst_n,
	input  btpc_pkg::calib_t calib,
	input  logic in_valid,
	output logic in_stall,
	input  logic [19:0] raw_t,
	input  logic [19:0] raw_p,
	output logic out_valid,
	input  logic out_stall,
	output btpc_pkg::front_t out_data
);

	localparam int NST = 8;

	logic [NST-1:0] vld_s;
	logic [NST:0] rdy;
	logic [NST-1:0] vin;

	assign vin = {vld_s[NST-2:0], in_valid};

	always_comb begin
		rdy[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (rdy[k]) vld_s[k] <= vin[k];
			end
		end
	end

	assign in_stall = !rdy[0];
	assign out_valid = vld_s[NST-1];

	// Stage 1
	logic signed [17:0] x1;
	logic signed [16:0] dt;
	logic signed [33:0] x1t2, ddf;
	logic signed [33:0] x1t2_s1;
	logic [31:0] dd_s1;
	logic [19:0] rp_s1;

	assign x1 = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
	assign dt = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, calib.t1});
	assign x1t2 = x1 * $signed(calib.t2);
	assign ddf = dt * dt;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x1t2_s1 <= x1t2;
			dd_s1 <= ddf[31:0];
			rp_s1 <= raw_p;
		end
	end

	// Stage 2
	logic signed [36:0] bt_full;
	logic signed [23:0] tfine;
	logic signed [23:0] tf_s2;
	logic [19:0] rp_s2;

	assign bt_full = $signed({1'b0, dd_s1[31:12]}) * $signed(calib.t3);
	assign tfine = $signed({x1t2_s1[33], x1t2_s1[33:11]})
		+ $signed({bt_full[36], bt_full[36:14]});

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			tf_s2 <= tfine;
			rp_s2 <= rp_s1;
		end
	end

	// Stage 3
	logic signed [27:0] t5;
	logic signed [19:0] tc;
	logic signed [15:0] tsat;
	logic signed [24:0] pa;
	logic signed [49:0] paa;
	logic signed [15:0] temp_s3;
	logic signed [24:0] pa_s3;
	logic [47:0] paa_s3;
	logic [19:0] rp_s3;

	assign t5 = $signed({{4{tf_s2[23]}}, tf_s2}) * 28'sd5 + 28'sd128;
	assign tc = t5[27:8];
	assign pa = $signed({tf_s2[23], tf_s2}) - btpc_pkg::T_FINE_REF;
	assign paa = pa * pa;

	always_comb begin
		if (tc > $signed({{4{1'b0}}, btpc_pkg::TEMP_MAX})) begin
			tsat = btpc_pkg::TEMP_MAX;
		end else if (tc < $signed({{4{1'b1}}, btpc_pkg::TEMP_MIN})) begin
			tsat = btpc_pkg::TEMP_MIN;
		end else begin
			tsat = tc[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			temp_s3 <= tsat;
			pa_s3 <= pa;
			paa_s3 <= paa[47:0];
			rp_s3 <= rp_s2;
		end
	end

	// Stage 4
	logic signed [48:0] p6l, p3l;
	logic signed [32:0] p6h, p3h;
	logic signed [40:0] pap5, pap2;
	logic signed [48:0] p6l_s4, p3l_s4;
	logic signed [32:0] p6h_s4, p3h_s4;
	logic signed [40:0] pap5_s4, pap2_s4;
	logic signed [15:0] temp_s4;
	logic [19:0] rp_s4;

	assign p6l = $signed(calib.p6) * $signed({1'b0, paa_s3[31:0]});
	assign p6h = $signed(calib.p6) * $signed({1'b0, paa_s3[47:32]});
	assign p3l = $signed(calib.p3) * $signed({1'b0, paa_s3[31:0]});
	assign p3h = $signed(calib.p3) * $signed({1'b0, paa_s3[47:32]});
	assign pap5 = pa_s3 * $signed(calib.p5);
	assign pap2 = pa_s3 * $signed(calib.p2);

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			p6l_s4 <= p6l;
			p6h_s4 <= p6h;
			p3l_s4 <= p3l;
			p3h_s4 <= p3h;
			pap5_s4 <= pap5;
			pap2_s4 <= pap2;
			temp_s4 <= temp_s3;
			rp_s4 <= rp_s3;
		end
	end

	// Stage 5
	logic signed [65:0] aap6, aap3;
	logic signed [65:0] aap6_s5, aap3_s5;
	logic signed [40:0] pap5_s5, pap2_s5;
	logic signed [15:0] temp_s5;
	logic [19:0] rp_s5;

	assign aap6 = ($signed({{33{p6h_s4[32]}}, p6h_s4}) <<< 32)
		+ $signed({{17{p6l_s4[48]}}, p6l_s4});
	assign aap3 = ($signed({{33{p3h_s4[32]}}, p3h_s4}) <<< 32)
		+ $signed({{17{p3l_s4[48]}}, p3l_s4});

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			aap6_s5 <= aap6;
			aap3_s5 <= aap3;
			pap5_s5 <= pap5_s4;
			pap2_s5 <= pap2_s4;
			temp_s5 <= temp_s4;
			rp_s5 <= rp_s4;
		end
	end

	// Stage 6
	logic signed [65:0] bsum;
	logic signed [58:0] a2;
	logic signed [65:0] b_s6;
	logic signed [58:0] a2_s6;
	logic signed [15:0] temp_s6;
	logic [19:0] rp_s6;

	assign bsum = aap6_s5
		+ ($signed({{25{pap5_s5[40]}}, pap5_s5}) <<< 17)
		+ ($signed({{50{calib.p4[15]}}, calib.p4}) <<< 35);
	assign a2 = $signed({aap3_s5[65], aap3_s5[65:8]})
		+ $signed({{6{pap2_s5[40]}}, pap2_s5, 12'b0});

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			b_s6 <= bsum;
			a2_s6 <= a2;
			temp_s6 <= temp_s5;
			rp_s6 <= rp_s5;
		end
	end

	// Stage 7
	logic signed [59:0] xv;
	logic [47:0] xl;
	logic signed [44:0] xh;
	logic [20:0] pd;
	logic signed [67:0] numv;
	logic [47:0] xl_s7;
	logic signed [44:0] xh_s7;
	logic signed [67:0] num_s7;
	logic signed [15:0] temp_s7;

	assign xv = $signed({a2_s6[58], a2_s6}) + btpc_pkg::P1_BIAS;
	assign xl = xv[31:0] * calib.p1;
	assign xh = $signed(xv[59:32]) * $signed({1'b0, calib.p1});
	assign pd = btpc_pkg::P_FULL - {1'b0, rp_s6};
	assign numv = $signed({16'b0, pd, 31'b0}) - $signed({{2{b_s6[65]}}, b_s6});

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			xl_s7 <= xl;
			xh_s7 <= xh;
			num_s7 <= numv;
			temp_s7 <= temp_s6;
		end
	end

	// Stage 8
	logic signed [77:0] prod;
	logic signed [80:0] nsc;
	btpc_pkg::front_t od_s8;

	assign prod = ($signed({{33{xh_s7[44]}}, xh_s7}) <<< 32) + $signed({30'b0, xl_s7});
	assign nsc = $signed({{13{num_s7[67]}}, num_s7}) * btpc_pkg::Q_SCALE;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			od_s8.temp <= temp_s7;
			od_s8.den <= prod[74:33];
			od_s8.num <= nsc[79:0];
		end
	end

	assign out_data = od_s8;

endmodule

// ===== rtl/btpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module btpc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  btpc_pkg::front_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output btpc_pkg::quot_t out_data
);

	localparam int QB = btpc_pkg::QBITS;
	localparam int DW = btpc_pkg::DEN_W;
	localparam int NW = btpc_pkg::NUM_W;
	localparam int NST = QB + 2;

	logic [NST-1:0] vld_s;
	logic [NST:0] rdy;
	logic [NST-1:0] vin;

	assign vin = {vld_s[NST-2:0], in_valid};

	always_comb begin
		rdy[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (rdy[k]) vld_s[k] <= vin[k];
			end
		end
	end

	assign in_stall = !rdy[0];
	assign out_valid = vld_s[NST-1];

	logic signed [15:0] temp_sk [0:NST-1];
	logic [NST-1:0] err_sk, neg_sk;
	logic [NST-1:1] ovf_sk;
	logic [DW-1:0] dm_sk [0:NST-2];
	logic [DW-1:0] rem_sk [1:NST-2];
	logic [QB-1:0] nq_sk [1:NST-1];
	logic [NW-1:0] nm_s0;

	// Magnitudes and sign of the quotient.
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			temp_sk[0] <= in_data.temp;
			err_sk[0] <= (in_data.den == '0);
			neg_sk[0] <= in_data.num[NW-1] ^ in_data.den[DW-1];
			nm_s0 <= in_data.num[NW-1] ? NW'(-in_data.num) : NW'(in_data.num);
			dm_sk[0] <= in_data.den[DW-1] ? DW'(-in_data.den) : DW'(in_data.den);
		end
	end

	// A quotient of 2^QB or more saturates.
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			temp_sk[1] <= temp_sk[0];
			err_sk[1] <= err_sk[0];
			neg_sk[1] <= neg_sk[0];
			dm_sk[1] <= dm_sk[0];
			ovf_sk[1] <= nm_s0[NW-1:QB] >= {1'b0, dm_sk[0]};
			rem_sk[1] <= nm_s0[NW-2:QB];
			nq_sk[1] <= nm_s0[QB-1:0];
		end
	end

	genvar k;
	generate
		for (k = 2; k < NST; k++) begin : g_step
			logic [DW:0] tr, df;
			logic ge;

			assign tr = {rem_sk[k-1], nq_sk[k-1][QB-1]};
			assign ge = tr >= {1'b0, dm_sk[k-1]};
			assign df = tr - {1'b0, dm_sk[k-1]};

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					temp_sk[k] <= temp_sk[k-1];
					err_sk[k] <= err_sk[k-1];
					neg_sk[k] <= neg_sk[k-1];
					ovf_sk[k] <= ovf_sk[k-1];
					nq_sk[k] <= {nq_sk[k-1][QB-2:0], ge};
				end
			end

			if (k < NST - 1) begin : g_keep
				always_ff @(posedge clk) begin
					if (rdy[k]) begin
						dm_sk[k] <= dm_sk[k-1];
						rem_sk[k] <= ge ? df[DW-1:0] : tr[DW-1:0];
					end
				end
			end
		end
	endgenerate

	assign out_data.temp = temp_sk[NST-1];
	assign out_data.err = err_sk[NST-1];
	assign out_data.neg = neg_sk[NST-1];
	assign out_data.qmag = ovf_sk[NST-1] ? {QB{1'b1}} : nq_sk[NST-1];

endmodule

// ===== rtl/btpc_back.sv =====
// Back pipeline: second-order pressure corrections, clamping and output register.
module btpc_back (
	input  logic clk,
	input  logic arst_n,
	input  btpc_pkg::calib_t calib,
	input  logic in_valid,
	output logic in_stall,
	input  btpc_pkg::quot_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] temperature_centi,
	output logic [31:0] pressure_q24_8,
	output logic error_flag
);

	localparam int NST = 5;

	logic [NST-1:0] vld_s;
	logic [NST:0] rdy;
	logic [NST-1:0] vin;

	assign vin = {vld_s[NST-2:0], in_valid};

	always_comb begin
		rdy[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < NST; k++) begin
				if (rdy[k]) vld_s[k] <= vin[k];
			end
		end
	end

	assign in_stall = !rdy[0];
	assign out_valid = vld_s[NST-1];

	// Stage 1
	logic signed [37:0] q_s1;
	logic signed [15:0] temp_s1;
	logic err_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			q_s1 <= in_data.neg ? -$signed({1'b0, in_data.qmag}) : $signed({1'b0, in_data.qmag});
			temp_s1 <= in_data.temp;
			err_s1 <= in_data.err;
		end
	end

	// Stage 2
	logic signed [49:0] qqf;
	logic signed [53:0] p8q;
	logic [48:0] qq_s2;
	logic signed [53:0] p8q_s2;
	logic signed [37:0] q_s2;
	logic signed [15:0] temp_s2;
	logic err_s2;

	assign qqf = $signed(q_s1[37:13]) * $signed(q_s1[37:13]);
	assign p8q = $signed(calib.p8) * q_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			qq_s2 <= qqf[48:0];
			p8q_s2 <= p8q;
			q_s2 <= q_s1;
			temp_s2 <= temp_s1;
			err_s2 <= err_s1;
		end
	end

	// Stage 3
	logic signed [48:0] v1l;
	logic signed [33:0] v1h;
	logic signed [48:0] v1l_s3;
	logic signed [33:0] v1h_s3;
	logic signed [34:0] v2_s3;
	logic signed [37:0] q_s3;
	logic signed [15:0] temp_s3;
	logic err_s3;

	assign v1l = $signed(calib.p9) * $signed({1'b0, qq_s2[31:0]});
	assign v1h = $signed(calib.p9) * $signed({1'b0, qq_s2[48:32]});

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			v1l_s3 <= v1l;
			v1h_s3 <= v1h;
			v2_s3 <= p8q_s2[53:19];
			q_s3 <= q_s2;
			temp_s3 <= temp_s2;
			err_s3 <= err_s2;
		end
	end

	// Stage 4
	logic signed [65:0] v1full;
	logic signed [40:0] v1_s4;
	logic signed [34:0] v2_s4;
	logic signed [37:0] q_s4;
	logic signed [15:0] temp_s4;
	logic err_s4;

	assign v1full = ($signed({{32{v1h_s3[33]}}, v1h_s3}) <<< 32)
		+ $signed({{17{v1l_s3[48]}}, v1l_s3});

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			v1_s4 <= v1full[65:25];
			v2_s4 <= v2_s3;
			q_s4 <= q_s3;
			temp_s4 <= temp_s3;
			err_s4 <= err_s3;
		end
	end

	// Stage 5: output register
	logic signed [41:0] psum;
	logic signed [35:0] pres;
	logic [31:0] pclamp;
	logic signed [15:0] temp_s5;
	logic [31:0] pres_s5;
	logic err_s5;

	assign psum = $signed({{4{q_s4[37]}}, q_s4}) + $signed({v1_s4[40], v1_s4})
		+ $signed({{7{v2_s4[34]}}, v2_s4});
	assign pres = $signed({{2{psum[41]}}, psum[41:8]})
		+ $signed({{16{calib.p7[15]}}, calib.p7, 4'b0});

	always_comb begin
		if (err_s4 || pres[35]) begin
			pclamp = '0;
		end else if (pres[34:32] != 3'b000) begin
			pclamp = '1;
		end else begin
			pclamp = pres[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			temp_s5 <= temp_s4;
			pres_s5 <= pclamp;
			err_s5 <= err_s4;
		end
	end

	assign temperature_centi = temp_s5;
	assign pressure_q24_8 = pres_s5;
	assign error_flag = err_s5;

endmodule

// ===== rtl/baro_temp_press_compensation.sv =====
// An accepted sample transfer reaches its result through the front, divider and back pipelines.
// Throughput: one sample per cycle while results are not stalled; every stage is a register and
// the divider retires one quotient bit per stage, so the 37-bit quotient sets the pipeline depth.
// A stalled result holds its own stage and every full stage behind it; empty stages upstream keep filling.
// Reset clears all valid bits and the calibration registers; payload registers are not reset.
// Top level of the barometric temperature and pressure compensation block.
module baro_temp_press_compensation (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [btpc_pkg::ADDR_W-1:0] paddr,
	input  logic [btpc_pkg::DATA_W-1:0] pwdata,
	output logic [btpc_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic sample_valid,
	output logic sample_stall,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	output logic result_valid,
	input  logic result_stall,
	output logic signed [15:0] temperature_centi,
	output logic [31:0] pressure_q24_8,
	output logic error_flag
);

	btpc_pkg::calib_t calib;
	btpc_pkg::front_t front_data;
	btpc_pkg::quot_t quot_data;
	logic front_valid, front_stall;
	logic quot_valid, quot_stall;

	btpc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.calib(calib)
	);

	btpc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.calib(calib),
		.in_valid(sample_valid),
		.in_stall(sample_stall),
		.raw_t(raw_temperature),
		.raw_p(raw_pressure),
		.out_valid(front_valid),
		.out_stall(front_stall),
		.out_data(front_data)
	);

	btpc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(front_valid),
		.in_stall(front_stall),
		.in_data(front_data),
		.out_valid(quot_valid),
		.out_stall(quot_stall),
		.out_data(quot_data)
	);

	btpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.calib(calib),
		.in_valid(quot_valid),
		.in_stall(quot_stall),
		.in_data(quot_data),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.temperature_centi(temperature_centi),
		.pressure_q24_8(pressure_q24_8),
		.error_flag(error_flag)
	);

endmodule

// ===== rtl/btpc_checker.sv =====
// Port-level checker for the compensation block and its bind.
module btpc_checker (
	input logic clk,
	input logic arst_n,
	input logic sample_stall,
	input logic result_valid,
	input logic result_stall,
	input logic signed [15:0] temperature_centi,
	input logic [31:0] pressure_q24_8,
	input logic error_flag
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(temperature_centi)
			&& $stable(pressure_q24_8) && $stable(error_flag))
		else $error("stalled result changed or dropped");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(!result_stall))
		else $error("result dropped without a transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_flag |-> pressure_q24_8 == 32'd0)
		else $error("pressure not zero on divisor error");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall |-> !sample_stall)
		else $error("input stalled while output drains");

endmodule

bind baro_temp_press_compensation btpc_checker u_btpc_checker (.*);

// ===== bench/baro_temp_press_compensation_checker.sv =====
// Checker that predicts and compares the compensation results of the barometric block.
module baro_temp_press_compensation_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [btpc_pkg::ADDR_W-1:0] paddr,
	input  logic [btpc_pkg::DATA_W-1:0] pwdata,
	input  logic sample_valid,
	input  logic sample_stall,
	input  logic [19:0] raw_temperature,
	input  logic [19:0] raw_pressure,
	input  logic result_valid,
	input  logic result_stall,
	input  logic signed [15:0] temperature_centi,
	input  logic [31:0] pressure_q24_8,
	input  logic error_flag,
	output int mismatches,
	output int outstanding,
	output int checked,
	output int error_results
);

	typedef struct {
		logic signed [15:0] temp;
		logic [31:0] pres;
		logic err;
	} reading_t;

	logic [31:0] calib_regs [0:5];
	reading_t expected_readings [$];

	function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
		longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint a, b, d, t_fine, temp, num, den, q, q1, r1, v1, v2, pres, hi, lo, x;
		reading_t r;
		adc_t = longint'(rt);
		adc_p = longint'(rp);
		t1 = longint'(calib_regs[btpc_pkg::REG_T1_T2][31:16]);
		t2 = longint'($signed(calib_regs[btpc_pkg::REG_T1_T2][15:0]));
		t3 = longint'($signed(calib_regs[btpc_pkg::REG_T3_P1][31:16]));
		p1 = longint'(calib_regs[btpc_pkg::REG_T3_P1][15:0]);
		p2 = longint'($signed(calib_regs[btpc_pkg::REG_P2_P3][31:16]));
		p3 = longint'($signed(calib_regs[btpc_pkg::REG_P2_P3][15:0]));
		p4 = longint'($signed(calib_regs[btpc_pkg::REG_P4_P5][31:16]));
		p5 = longint'($signed(calib_regs[btpc_pkg::REG_P4_P5][15:0]));
		p6 = longint'($signed(calib_regs[btpc_pkg::REG_P6_P7][31:16]));
		p7 = longint'($signed(calib_regs[btpc_pkg::REG_P6_P7][15:0]));
		p8 = longint'($signed(calib_regs[btpc_pkg::REG_P8_P9][31:16]));
		p9 = longint'($signed(calib_regs[btpc_pkg::REG_P8_P9][15:0]));
		a = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
		d = (adc_t >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		t_fine = a + b;
		temp = (t_fine * 5 + 128) >>> 8;
		if (temp > 32767) temp = 32767;
		if (temp < -32768) temp = -32768;
		a = t_fine - 128000;
		b = a * a * p6;
		b = b + a * p5 * (64'sd1 << 17);
		b = b + p4 * (64'sd1 << 35);
		a = ((a * a * p3) >>> 8) + a * p2 * 4096;
		x = (64'sd1 << 47) + a;
		hi = x >>> 16;
		lo = x - hi * 65536;
		den = (hi * p1 + ((lo * p1) >>> 16)) >>> 17;
		r.temp = temp[15:0];
		r.err = 1'b0;
		r.pres = '0;
		if (den == 0) begin
			r.err = 1'b1;
		end else begin
			num = (1048576 - adc_p) * (64'sd1 << 31) - b;
			q1 = num / den;
			r1 = num % den;
			if (q1 > 44000000) begin
				q = 64'sd137438953471;
			end else if (q1 < -44000000) begin
				q = -64'sd137438953471;
			end else begin
				q = q1 * 3125 + (r1 * 3125) / den;
				if (q > 64'sd137438953471) q = 64'sd137438953471;
				if (q < -64'sd137438953471) q = -64'sd137438953471;
			end
			v1 = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
			v2 = (p8 * q) >>> 19;
			pres = ((q + v1 + v2) >>> 8) + p7 * 16;
			if (pres < 0) pres = 0;
			if (pres > 64'sd4294967295) pres = 64'sd4294967295;
			r.pres = pres[31:0];
		end
		return r;
	endfunction

	assign outstanding = expected_readings.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) calib_regs[i] <= '0;
			mismatches <= 0;
			checked <= 0;
			error_results <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[4:2] <= btpc_pkg::REG_P8_P9)
				calib_regs[paddr[4:2]] <= pwdata;
			if (sample_valid && !sample_stall)
				expected_readings.push_back(compensate(raw_temperature, raw_pressure));
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result transfer with no sample pending", $realtime);
					mismatches <= mismatches + 1;
				end else begin
					e = expected_readings.pop_front();
					checked <= checked + 1;
					if (e.err) error_results <= error_results + 1;
					if (e.temp !== temperature_centi || e.pres !== pressure_q24_8 ||
					    e.err !== error_flag) begin
						if (mismatches < 10)
							$display("%0t: expected temp %0d pres %h err %b, got %0d %h %b",
							         $realtime, e.temp, e.pres, e.err,
							         temperature_centi, pressure_q24_8, error_flag);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end

endmodule

// ===== bench/baro_temp_press_compensation_tb.sv =====
// Top of the testbench: clock, reset, calibration writes, sample stimulus and verdict.
module baro_temp_press_compensation_tb;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [btpc_pkg::ADDR_W-1:0] paddr;
	logic [btpc_pkg::DATA_W-1:0] pwdata, prdata;
	logic sample_valid, sample_stall;
	logic [19:0] raw_temperature, raw_pressure;
	logic result_valid, result_stall;
	logic signed [15:0] temperature_centi;
	logic [31:0] pressure_q24_8;
	logic error_flag;
	logic calm;
	int mismatches, outstanding, checked, error_results;
	int quiet_cycles;
	int sent;

	baro_temp_press_compensation dut (.*);

	baro_temp_press_compensation_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) result_stall <= 1'b0;
		else result_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("** baro_temp_press_compensation: FAILED **");
			$finish;
		end
	end

	task automatic write_calib(input btpc_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_calib(input logic [31:0] v0, v1, v2, v3, v4, v5);
		write_calib(btpc_pkg::REG_T1_T2, v0);
		write_calib(btpc_pkg::REG_T3_P1, v1);
		write_calib(btpc_pkg::REG_P2_P3, v2);
		write_calib(btpc_pkg::REG_P4_P5, v3);
		write_calib(btpc_pkg::REG_P6_P7, v4);
		write_calib(btpc_pkg::REG_P8_P9, v5);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp);
		if (!calm && $urandom_range(99) < 26) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		raw_temperature <= rt;
		raw_pressure <= rp;
		do @(posedge clk); while (sample_stall);
		sent++;
	endtask

	task automatic random_samples(input int count);
		logic [19:0] rt, rp;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0, 1: begin
					rt = 20'($urandom);
					rp = 20'($urandom);
				end
				2: begin
					rt = $urandom_range(1) ? 20'hFFFFF : 20'h0;
					rp = $urandom_range(1) ? 20'hFFFFF : 20'($urandom);
				end
				default: begin
					rt = 20'(32'd519888 + $urandom_range(60000) - 32'd30000);
					rp = 20'(32'd415148 + $urandom_range(200000) - 32'd100000);
				end
			endcase
			send_sample(rt, rp);
		end
	endtask

	function automatic logic [31:0] nudge(input logic [31:0] v);
		return {v[31:16] + 16'($urandom_range(64)) - 16'd32,
		        v[15:0] + 16'($urandom_range(64)) - 16'd32};
	endfunction

	initial begin
		logic [31:0] typ [0:5];
		typ = '{{16'd27504, 16'd26435}, {-16'sd1000, 16'd36477}, {-16'sd10685, 16'sd3024},
		        {16'sd2855, 16'sd140}, {-16'sd7, 16'sd15500}, {-16'sd14600, 16'sd6000}};
		calm = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		raw_temperature = '0;
		raw_pressure = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With calibration at reset the pressure divisor is zero on every transfer.
		send_sample(20'h0, 20'h0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'd519888, 20'd415148);
		drain();

		load_calib(typ[0], typ[1], typ[2], typ[3], typ[4], typ[5]);
		send_sample(20'd519888, 20'd415148);
		send_sample(20'h0, 20'h0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'h0);
		send_sample(20'h80000, 20'h80000);
		send_sample(20'h55555, 20'hAAAAA);
		send_sample(20'hAAAAA, 20'h55555);
		drain();

		// Extreme coefficients push temperature into saturation and the quotient into its limit.
		load_calib(32'hFFFF_7FFF, 32'h7FFF_0001, 32'h7FFF_7FFF, 32'h8000_8000,
		           32'h7FFF_8000, 32'h7FFF_7FFF);
		send_sample(20'h0, 20'h0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h0, 20'hFFFFF);
		send_sample(20'hFFFFF, 20'h0);
		drain();
		load_calib(32'h0000_8000, 32'h8000_FFFF, 32'h8000_8000, 32'h7FFF_7FFF,
		           32'h8000_7FFF, 32'h8000_8000);
		send_sample(20'h0, 20'h0);
		send_sample(20'hFFFFF, 20'hFFFFF);
		send_sample(20'h12345, 20'hFEDCB);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_calib(typ[0], typ[1], typ[2], typ[3], typ[4], typ[5]);
				1: load_calib($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				2: load_calib('1, '1, '1, '1, '1, '1);
				3: load_calib(nudge(typ[0]), nudge(typ[1]), nudge(typ[2]), nudge(typ[3]),
				              nudge(typ[4]), nudge(typ[5]));
				4: load_calib($urandom, {16'($urandom), 16'($urandom_range(3))}, $urandom,
				              $urandom, $urandom, $urandom);
				default: load_calib(nudge(typ[0]), {16'($urandom), 16'($urandom)},
				                    nudge(typ[2]), nudge(typ[3]), nudge(typ[4]),
				                    nudge(typ[5]));
			endcase
			calm = (phase == 3);
			random_samples(140);
			if (phase == 0) begin
				sample_valid <= 1'b0;
				while (outstanding != 0) @(posedge clk);
			end
			random_samples(135);
			drain();
		end
		calm = 1'b0;

		$display("Sent %0d samples over ten calibration sets, %0d results checked,",
		         sent, checked);
		$display("%0d of them with the pressure divisor at zero.", error_results);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** baro_temp_press_compensation: PASSED **");
		end else begin
			$display("** baro_temp_press_compensation: FAILED **");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/btpc_pkg.sv
rtl/btpc_cfg.sv
rtl/btpc_front.sv
rtl/btpc_div.sv
rtl/btpc_back.sv
rtl/baro_temp_press_compensation.sv
rtl/btpc_checker.sv
bench/baro_temp_press_compensation_checker.sv
bench/baro_temp_press_compensation_tb.sv
